@@ sv/hrp_pkg.sv @@
// hrp_pkg: shared types, character constants and match tables for the
// HTTP request head parser. No dependencies; imported by every hrp module.
`timescale 1ns / 1ps

package hrp_pkg;

  localparam int MAX_HEAD_BYTES = 8192;
  localparam int COUNT_W = 14;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SP    = 8'h20;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  // GET, POST, PUT
  localparam logic [7:0] METH_CHARS [3][4] = '{
    '{8'h47, 8'h45, 8'h54, 8'h00},
    '{8'h50, 8'h4F, 8'h53, 8'h54},
    '{8'h50, 8'h55, 8'h54, 8'h00}
  };
  localparam logic [2:0] METH_LEN [3] = '{3'd3, 3'd4, 3'd3};

  // HTTP/1.0, HTTP/1.1, HTTP/2, HTTP/3
  localparam logic [7:0] VER_CHARS [4][8] = '{
    '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E, 8'h30},
    '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E, 8'h31},
    '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h32, 8'h00, 8'h00},
    '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h33, 8'h00, 8'h00}
  };
  localparam logic [3:0] VER_LEN [4] = '{4'd8, 4'd8, 4'd6, 4'd6};

  localparam logic [1:0] ERR_MALFORMED = 2'd0;
  localparam logic [1:0] ERR_METHOD    = 2'd1;
  localparam logic [1:0] ERR_VERSION   = 2'd2;
  localparam logic [1:0] ERR_TRUNC     = 2'd3;

  typedef enum logic [2:0] {
    PH_METHOD  = 3'd0,
    PH_PATH    = 3'd1,
    PH_VERSION = 3'd2,
    PH_KEY     = 3'd3,
    PH_VALUE   = 3'd4,
    PH_DONE    = 3'd5,
    PH_ERROR   = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_METHOD  = 3'd0,
    ROLE_PATH    = 3'd1,
    ROLE_VERSION = 3'd2,
    ROLE_KEY     = 3'd3,
    ROLE_VALUE   = 3'd4,
    ROLE_SEP     = 3'd5,
    ROLE_DONE    = 3'd6,
    ROLE_ERROR   = 3'd7
  } role_t;

  typedef struct packed {
    phase_t             phase;
    logic               pending_cr;
    logic               line_has_bytes;
    logic [COUNT_W-1:0] byte_count;
    logic [2:0]         method_position;
    logic [2:0]         method_candidates;
    logic [3:0]         version_position;
    logic [3:0]         version_candidates;
  } parse_st_t;

  localparam parse_st_t PARSE_RESET = '{
    phase:              PH_METHOD,
    pending_cr:         1'b0,
    line_has_bytes:     1'b0,
    byte_count:         '0,
    method_position:    3'd0,
    method_candidates:  3'b111,
    version_position:   4'd0,
    version_candidates: 4'b1111
  };

  typedef struct packed {
    role_t      role;
    logic [7:0] out_byte;
    logic [1:0] method_code;
    logic [1:0] version_code;
    logic [1:0] error_code;
  } result_t;

  // One queued word: the results caused by one input byte (one or two).
  typedef struct packed {
    logic    two;
    result_t res0;
    result_t res1;
  } run_t;

  typedef struct packed {
    parse_st_t st;
    role_t     role;
  } ord_t;

  function automatic result_t make_result(role_t role, logic [7:0] b,
                                          logic [1:0] m, logic [1:0] v,
                                          logic [1:0] e);
    result_t r;
    r.role = role;
    r.out_byte = b;
    r.method_code = m;
    r.version_code = v;
    r.error_code = e;
    return r;
  endfunction

  // Plain content byte: route by phase, update matchers and split points.
  function automatic ord_t ordinary(parse_st_t s, logic [7:0] b);
    ord_t o;
    o.st = s;
    o.role = ROLE_VALUE;
    case (s.phase)
      PH_METHOD: begin
        if (b == CHAR_SP) begin
          o.st.phase = PH_PATH;
          o.role = ROLE_SEP;
        end else begin
          for (int i = 0; i < 3; i++) begin
            if (s.method_position >= METH_LEN[i] ||
                METH_CHARS[i][s.method_position[1:0]] != b)
              o.st.method_candidates[i] = 1'b0;
          end
          if (s.method_position != 3'd7)
            o.st.method_position = s.method_position + 3'd1;
          o.role = ROLE_METHOD;
        end
      end
      PH_PATH: begin
        if (b == CHAR_SP) begin
          o.st.phase = PH_VERSION;
          o.role = ROLE_SEP;
        end else begin
          o.role = ROLE_PATH;
        end
      end
      PH_VERSION: begin
        for (int i = 0; i < 4; i++) begin
          if (s.version_position >= VER_LEN[i] ||
              VER_CHARS[i][s.version_position[2:0]] != b)
            o.st.version_candidates[i] = 1'b0;
        end
        if (s.version_position != 4'd15)
          o.st.version_position = s.version_position + 4'd1;
        o.role = ROLE_VERSION;
      end
      PH_KEY: begin
        if (b == CHAR_COLON) begin
          o.st.phase = PH_VALUE;
          o.role = ROLE_SEP;
        end else begin
          o.st.line_has_bytes = 1'b1;
          o.role = ROLE_KEY;
        end
      end
      default: o.role = ROLE_VALUE;
    endcase
    return o;
  endfunction

endpackage

@@ sv/hrp_front.sv @@
// hrp_front: byte classifier. Holds the parse state, tags each accepted byte
// and pushes its results as one run word. Depends on hrp_pkg.
`timescale 1ns / 1ps

module hrp_front
  import hrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       end_of_data,
  input  logic       restart,
  input  logic       q_full,
  output logic       push,
  output run_t       push_run
);

  parse_st_t st, st_next;
  parse_st_t s0, s1, s2;
  ord_t      flush_ord, main_ord;
  result_t   flush_res, main_res;
  logic      active, trunc, crlf, flush, has_main, accept;
  logic      m_found, v_found;
  logic [1:0] m_code, v_code;

  assign in_stall = q_full;
  assign accept = in_valid && !q_full;

  always_comb begin
    s0 = restart ? PARSE_RESET : st;
    active = (s0.phase != PH_DONE) && (s0.phase != PH_ERROR);
    trunc = end_of_data || (data_byte == CHAR_NUL) ||
            ((15'(s0.byte_count) + 15'd1) >= 15'(MAX_HEAD_BYTES));
    crlf = s0.pending_cr && (data_byte == CHAR_LF);

    // a held CR that is not followed by LF is content of the current field
    flush = s0.pending_cr && !crlf;
    flush_ord = ordinary(s0, CHAR_CR);
    flush_res = make_result(flush_ord.role, CHAR_CR, 2'd0, 2'd0, 2'd0);
    s1 = flush ? flush_ord.st : s0;
    s1.pending_cr = 1'b0;

    // head-complete match: first surviving candidate of full length
    m_found = 1'b0;
    m_code = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if (!m_found && s1.method_candidates[i] && METH_LEN[i] == s1.method_position) begin
        m_found = 1'b1;
        m_code = 2'(i);
      end
    end
    v_found = 1'b0;
    v_code = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (!v_found && s1.version_candidates[i] && VER_LEN[i] == s1.version_position) begin
        v_found = 1'b1;
        v_code = 2'(i);
      end
    end

    main_ord = ordinary(s1, data_byte);
    s2 = s1;
    has_main = 1'b1;
    main_res = make_result(ROLE_ERROR, 8'h00, 2'd0, 2'd0, ERR_TRUNC);
    if (crlf) begin
      if (s1.phase == PH_METHOD || s1.phase == PH_PATH ||
          (s1.phase == PH_KEY && s1.line_has_bytes)) begin
        s2.phase = PH_ERROR;
        main_res = make_result(ROLE_ERROR, 8'h00, 2'd0, 2'd0, ERR_MALFORMED);
      end else if (s1.phase == PH_KEY) begin
        if (!m_found) begin
          s2.phase = PH_ERROR;
          main_res = make_result(ROLE_ERROR, 8'h00, 2'd0, 2'd0, ERR_METHOD);
        end else if (!v_found) begin
          s2.phase = PH_ERROR;
          main_res = make_result(ROLE_ERROR, 8'h00, 2'd0, 2'd0, ERR_VERSION);
        end else begin
          s2.phase = PH_DONE;
          main_res = make_result(ROLE_DONE, 8'h00, m_code, v_code, 2'd0);
        end
      end else if (trunc) begin
        s2.phase = PH_ERROR;
      end else begin
        s2.phase = PH_KEY;
        s2.line_has_bytes = 1'b0;
        main_res = make_result(ROLE_SEP, CHAR_LF, 2'd0, 2'd0, 2'd0);
      end
    end else if (trunc) begin
      s2.phase = PH_ERROR;
    end else if (data_byte == CHAR_CR) begin
      s2.pending_cr = 1'b1;
      has_main = 1'b0;
    end else begin
      s2 = main_ord.st;
      main_res = make_result(main_ord.role, data_byte, 2'd0, 2'd0, 2'd0);
    end

    if (s2.phase != PH_DONE && s2.phase != PH_ERROR)
      s2.byte_count = s1.byte_count + COUNT_W'(1);

    st_next = st;
    if (accept)
      st_next = active ? s2 : s0;

    push = accept && active && (flush || has_main);
    push_run.two = flush && has_main;
    push_run.res0 = flush ? flush_res : main_res;
    push_run.res1 = main_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= PARSE_RESET;
    end else begin
      st <= st_next;
    end
  end

endmodule

@@ sv/hrp_queue.sv @@
// hrp_queue: short FIFO of run words between classifier and output stage.
// Depends on hrp_pkg.
`timescale 1ns / 1ps

module hrp_queue
  import hrp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  run_t push_run,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output run_t head_run
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  run_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_run = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ sv/hrp_back.sv @@
// hrp_back: output stage. Loads one run word from the queue into a register
// and presents its results one per cycle while out_stall is low. Depends on hrp_pkg.
`timescale 1ns / 1ps

module hrp_back
  import hrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  run_t       head_run,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] role,
  output logic [7:0] out_byte,
  output logic [1:0] method_code,
  output logic [1:0] version_code,
  output logic [1:0] error_code,
  output logic       last_of_run
);

  run_t    run;
  logic    hold_valid;
  logic    sel;
  logic    last, taken;
  result_t cur;

  assign last = !run.two || sel;
  assign taken = hold_valid && !out_stall;
  assign pop = head_valid && (!hold_valid || (taken && last));
  assign cur = sel ? run.res1 : run.res0;

  assign out_valid = hold_valid;
  assign role = cur.role;
  assign out_byte = cur.out_byte;
  assign method_code = cur.method_code;
  assign version_code = cur.version_code;
  assign error_code = cur.error_code;
  assign last_of_run = last;

  always_ff @(posedge clk) begin
    if (pop) begin
      run <= head_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      sel <= 1'b0;
    end else if (taken && !last) begin
      sel <= 1'b1;
    end else if (pop) begin
      hold_valid <= 1'b1;
      sel <= 1'b0;
    end else if (taken) begin
      hold_valid <= 1'b0;
    end
  end

endmodule

@@ sv/http_request_head_parser.sv @@
// http_request_head_parser: top level of the HTTP/1 request head parser.
// Instantiates hrp_front, hrp_queue and hrp_back; types from hrp_pkg.
//
// Usage:
//  - Input channel: in_valid / in_stall carry one request byte per word with
//    end_of_data and restart. A word is taken on a clock edge with in_valid
//    high and in_stall low. restart clears the parser before its byte.
//  - Output channel: out_valid / out_stall carry one tagged result per word
//    (role, out_byte, method_code, version_code, error_code, last_of_run).
//    A byte yields zero, one or two results; last_of_run marks the last.
//  - Throughput: one input byte per cycle while in_stall is low. The output
//    delivers one result per cycle while out_stall is low, so a byte that
//    yields two results (a flushed CR plus its own result) holds the output
//    for both; the 4-word run queue absorbs that.
//  - Path: a byte's run word is written to the queue on the edge that takes
//    it, then loaded into the output register that drives the output ports.
//  - Stall: while out_stall is high the current result holds steady; the
//    front keeps taking bytes until the run queue fills, then raises
//    in_stall (driven only by queue fullness).
//  - Reset (rst, synchronous): parse state back to the method field with
//    all matchers open, queue emptied, output register invalid.
//  - After head done or an error, bytes are taken and dropped until restart.
`timescale 1ns / 1ps

module http_request_head_parser
  import hrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       end_of_data,
  input  logic       restart,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] role,
  output logic [7:0] out_byte,
  output logic [1:0] method_code,
  output logic [1:0] version_code,
  output logic [1:0] error_code,
  output logic       last_of_run
);

  // front -> queue
  logic q_full;
  logic push;
  run_t push_run;

  // queue -> back
  logic head_valid;
  run_t head_run;
  logic pop;

  hrp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .end_of_data(end_of_data),
    .restart    (restart),
    .q_full     (q_full),
    .push       (push),
    .push_run   (push_run)
  );

  hrp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_run  (push_run),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_run  (head_run)
  );

  hrp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_run    (head_run),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .role        (role),
    .out_byte    (out_byte),
    .method_code (method_code),
    .version_code(version_code),
    .error_code  (error_code),
    .last_of_run (last_of_run)
  );

endmodule

@@ bench/tb_http_request_head_parser.sv @@
// tb_http_request_head_parser: self-checking bench for the HTTP request head
// parser. Random and directed request bytes in, tagged words checked against
// a local parse model. Depends on hrp_pkg and http_request_head_parser.
`timescale 1ns / 1ps

module tb_http_request_head_parser;
  import hrp_pkg::*;

  // One input word: a request byte plus its two flags.
  typedef struct {
    logic [7:0] b;
    logic       eod;
    logic       rs;
  } byte_word_t;

  // One output word as the parser should tag it.
  typedef struct {
    role_t      role;
    logic [7:0] b;
    logic [1:0] meth;
    logic [1:0] ver;
    logic [1:0] err;
    logic       last;
  } tag_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic       end_of_data = 1'b0;
  logic       restart = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [2:0] role;
  logic [7:0] out_byte;
  logic [1:0] method_code;
  logic [1:0] version_code;
  logic [1:0] error_code;
  logic       last_of_run;

  http_request_head_parser u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .end_of_data  (end_of_data),
    .restart      (restart),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .role         (role),
    .out_byte     (out_byte),
    .method_code  (method_code),
    .version_code (version_code),
    .error_code   (error_code),
    .last_of_run  (last_of_run)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Known method and version spellings, in code order.
  string method_txt [3] = '{"GET", "POST", "PUT"};
  string version_txt [4] = '{"HTTP/1.0", "HTTP/1.1", "HTTP/2", "HTTP/3"};

  byte_word_t request_bytes [$];   // words waiting for the driver
  tag_word_t  expected_tags [$];   // tagged words still owed by the parser
  tag_word_t  step_tags [$];       // words caused by the byte being modeled
  logic [7:0] head_bytes [$];      // request under construction

  int mismatches = 0;
  int bytes_queued = 0;
  int junk_queued = 0;
  int bytes_taken = 0;
  int words_seen = 0;
  int heads_done = 0;
  int heads_failed = 0;
  int cycle_no = 0;

  // Random idling and stalls pause for the last stretch of each cycle_no period.
  wire calm = (cycle_no % 5000) >= 3800;

  always @(posedge clk) cycle_no <= cycle_no + 1;

  // ---------------------------------------------------------------------
  // Parse model: the parser's state as the bench sees it.
  // ---------------------------------------------------------------------
  phase_t     cur_phase;
  logic       cr_held;       // CR waiting to see if an LF follows
  logic       key_started;   // current header line has key bytes
  int         head_len;      // bytes counted toward the head limit
  logic [2:0] meth_pos;
  logic [2:0] meth_alive;    // method spellings still matching
  logic [3:0] ver_pos;
  logic [3:0] ver_alive;     // version spellings still matching

  task automatic clear_parser();
    cur_phase   = PH_METHOD;
    cr_held     = 1'b0;
    key_started = 1'b0;
    head_len    = 0;
    meth_pos    = 3'd0;
    meth_alive  = 3'b111;
    ver_pos     = 4'd0;
    ver_alive   = 4'b1111;
  endtask

  task automatic add_tag(input role_t r, input logic [7:0] b, input logic [1:0] m,
                         input logic [1:0] v, input logic [1:0] e);
    tag_word_t t;
    t.role = r;
    t.b = b;
    t.meth = m;
    t.ver = v;
    t.err = e;
    t.last = 1'b0;
    step_tags.push_back(t);
  endtask

  task automatic fail_head(input logic [1:0] code);
    cur_phase = PH_ERROR;
    add_tag(ROLE_ERROR, 8'h00, 2'd0, 2'd0, code);
  endtask

  // Role of a plain content byte; moves split points and narrows the matchers.
  function automatic role_t route_byte(logic [7:0] b);
    role_t r;
    r = ROLE_VALUE;
    case (cur_phase)
      PH_METHOD: begin
        if (b == CHAR_SP) begin
          cur_phase = PH_PATH;
          r = ROLE_SEP;
        end else begin
          for (int i = 0; i < 3; i++)
            if (meth_pos >= method_txt[i].len() || method_txt[i][meth_pos] != b)
              meth_alive[i] = 1'b0;
          if (meth_pos != 3'd7) meth_pos = meth_pos + 3'd1;
          r = ROLE_METHOD;
        end
      end
      PH_PATH: begin
        if (b == CHAR_SP) begin
          cur_phase = PH_VERSION;
          r = ROLE_SEP;
        end else begin
          r = ROLE_PATH;
        end
      end
      PH_VERSION: begin
        for (int i = 0; i < 4; i++)
          if (ver_pos >= version_txt[i].len() || version_txt[i][ver_pos] != b)
            ver_alive[i] = 1'b0;
        if (ver_pos != 4'd15) ver_pos = ver_pos + 4'd1;
        r = ROLE_VERSION;
      end
      PH_KEY: begin
        if (b == CHAR_COLON) begin
          cur_phase = PH_VALUE;
          r = ROLE_SEP;
        end else begin
          key_started = 1'b1;
          r = ROLE_KEY;
        end
      end
      default: r = ROLE_VALUE;
    endcase
    return r;
  endfunction

  // Model one accepted byte and queue the words it must produce.
  task automatic parse_byte(input logic [7:0] b, input logic eod, input logic rs);
    logic trunc;
    logic crlf;
    int   mi;
    int   vi;
    step_tags.delete();
    if (rs) clear_parser();
    // finished heads swallow bytes silently until the next restart
    if (cur_phase == PH_DONE || cur_phase == PH_ERROR) return;
    trunc = eod || b == CHAR_NUL || head_len + 1 >= MAX_HEAD_BYTES;
    crlf = cr_held && b == CHAR_LF;
    // a held CR not followed by LF is just a content byte after all
    if (cr_held && !crlf) add_tag(route_byte(CHAR_CR), CHAR_CR, 2'd0, 2'd0, 2'd0);
    cr_held = 1'b0;
    if (crlf) begin
      if (cur_phase == PH_METHOD || cur_phase == PH_PATH ||
          (cur_phase == PH_KEY && key_started)) begin
        fail_head(ERR_MALFORMED);
      end else if (cur_phase == PH_KEY) begin
        // empty line: head complete, resolve method and version
        mi = -1;
        vi = -1;
        for (int i = 0; i < 3; i++)
          if (mi < 0 && meth_alive[i] && method_txt[i].len() == meth_pos) mi = i;
        for (int i = 0; i < 4; i++)
          if (vi < 0 && ver_alive[i] && version_txt[i].len() == ver_pos) vi = i;
        if (mi < 0) begin
          fail_head(ERR_METHOD);
        end else if (vi < 0) begin
          fail_head(ERR_VERSION);
        end else begin
          cur_phase = PH_DONE;
          add_tag(ROLE_DONE, 8'h00, mi[1:0], vi[1:0], 2'd0);
        end
      end else if (trunc) begin
        fail_head(ERR_TRUNC);
      end else begin
        cur_phase = PH_KEY;
        key_started = 1'b0;
        add_tag(ROLE_SEP, CHAR_LF, 2'd0, 2'd0, 2'd0);
      end
    end else if (trunc) begin
      fail_head(ERR_TRUNC);
    end else if (b == CHAR_CR) begin
      cr_held = 1'b1;
    end else begin
      add_tag(route_byte(b), b, 2'd0, 2'd0, 2'd0);
    end
    if (cur_phase != PH_DONE && cur_phase != PH_ERROR) head_len++;
    if (step_tags.size() > 0) step_tags[step_tags.size() - 1].last = 1'b1;
    foreach (step_tags[i]) expected_tags.push_back(step_tags[i]);
  endtask

  // ---------------------------------------------------------------------
  // Request builders
  // ---------------------------------------------------------------------
  function automatic logic [7:0] pick_byte(input logic [7:0] x0, x1, x2);
    logic [7:0] c;
    do c = 8'($urandom_range(255, 1)); while (c == x0 || c == x1 || c == x2);
    return c;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic eod, input logic rs);
    byte_word_t w;
    w.b = b;
    w.eod = eod;
    w.rs = rs;
    request_bytes.push_back(w);
    bytes_queued++;
  endtask

  task automatic put(input logic [7:0] b);
    head_bytes.push_back(b);
  endtask

  task automatic put_crlf();
    put(CHAR_CR);
    put(CHAR_LF);
  endtask

  task automatic put_string(input string s);
    for (int p = 0; p < s.len(); p++) put(s[p]);
  endtask

  // Method or version spelling; when damaged it is cut short, grown,
  // has one letter changed, or is left out.
  task automatic put_token(input string s, input bit bad, input logic [7:0] stop);
    int n;
    int k;
    int mode;
    n = s.len();
    mode = bad ? $urandom_range(3) : 4;
    k = $urandom_range(n - 1);
    if (mode == 0) n = n - 1;
    else if (mode == 3) n = 0;
    for (int p = 0; p < n; p++)
      put((mode == 2 && p == k) ? pick_byte(stop, CHAR_CR, s[p]) : s[p]);
    if (mode == 1) put(pick_byte(stop, CHAR_CR, CHAR_NUL));
  endtask

  // Free text without stop or CR, except for an odd lone CR that is
  // followed by something other than LF (it must be flushed as content).
  task automatic put_text(input int len, input logic [7:0] stop);
    for (int p = 0; p < len; p++) begin
      if ($urandom_range(15) == 0) begin
        put(CHAR_CR);
        put(pick_byte(CHAR_LF, CHAR_CR, stop));
      end else begin
        put(pick_byte(stop, CHAR_CR, CHAR_CR));
      end
    end
  endtask

  // early_crlf: 1 ends the line inside the method, 2 inside the path.
  task automatic build_head(input int early_crlf, input bit bad_meth, input bit bad_ver,
                            input bit no_colon);
    int nh;
    int bad_line;
    head_bytes.delete();
    put_token(method_txt[$urandom_range(2)], bad_meth, CHAR_SP);
    if (early_crlf == 1) begin
      put_crlf();
      return;
    end
    put(CHAR_SP);
    put_text($urandom_range(6, 1), CHAR_SP);
    if (early_crlf == 2) begin
      put_crlf();
      return;
    end
    put(CHAR_SP);
    put_token(version_txt[$urandom_range(3)], bad_ver, CHAR_CR);
    put_crlf();
    nh = $urandom_range(2) + (no_colon ? 1 : 0);
    bad_line = no_colon ? $urandom_range(nh - 1) : -1;
    for (int l = 0; l < nh; l++) begin
      if (l == bad_line) begin
        put_text($urandom_range(4, 1), CHAR_COLON);
      end else begin
        put_text($urandom_range(4), CHAR_COLON);
        put(CHAR_COLON);
        if ($urandom_range(3) != 0) put(CHAR_SP);
        put_text($urandom_range(5), CHAR_CR);
      end
      put_crlf();
    end
    put_crlf();
  endtask

  // Queue the built request; restart rides on its first byte.
  task automatic send_head(input bit eod_last);
    foreach (head_bytes[i])
      push_byte(head_bytes[i], eod_last && i == head_bytes.size() - 1, i == 0);
  endtask

  task automatic shorten_head();
    int keep;
    keep = $urandom_range(head_bytes.size() - 1) + 1;
    while (head_bytes.size() > keep) void'(head_bytes.pop_back());
  endtask

  task automatic add_random_request();
    int k;
    bit bm;
    bit bv;
    k = $urandom_range(99);
    bm = $urandom_range(9) == 0;
    bv = $urandom_range(9) == 0;
    if (k < 60) begin
      build_head(0, bm, bv, 1'b0);
      send_head(1'b0);
      // trailing bytes after the head are dropped by the parser
      repeat ($urandom_range(2)) begin
        push_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
        junk_queued++;
      end
    end else if (k < 68) begin
      build_head(0, 1'b0, 1'b0, 1'b1);
      send_head(1'b0);
    end else if (k < 74) begin
      build_head($urandom_range(2, 1), bm, 1'b0, 1'b0);
      send_head(1'b0);
    end else if (k < 82) begin
      build_head(0, bm, bv, 1'b0);
      shorten_head();
      send_head(1'b1);
    end else if (k < 88) begin
      build_head(0, bm, bv, 1'b0);
      head_bytes[$urandom_range(head_bytes.size() - 1)] = CHAR_NUL;
      send_head(1'b0);
    end else if (k < 94) begin
      // abandoned mid-head; the next restart has to clear it
      build_head(0, bm, bv, 1'b0);
      shorten_head();
      send_head(1'b0);
    end else begin
      push_byte(8'($urandom_range(255)), 1'($urandom_range(9) == 0), 1'b1);
      repeat ($urandom_range(11))
        push_byte(8'($urandom_range(255)), 1'($urandom_range(9) == 0),
                  1'($urandom_range(4) == 0));
    end
  endtask

  task automatic fill_random(input int n);
    int start;
    start = bytes_queued - junk_queued;
    while (bytes_queued - junk_queued - start < n) add_random_request();
  endtask

  // ---------------------------------------------------------------------
  // Driver: feeds request_bytes, holds a word while stalled, and models
  // each byte on the edge that accepts it.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : drive_blk
    byte_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
      clear_parser();
    end else begin
      if (in_valid && !in_stall) begin
        parse_byte(data_byte, end_of_data, restart);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (request_bytes.size() > 0 && (calm || $urandom_range(99) >= 20)) begin
          w = request_bytes.pop_front();
          in_valid    <= 1'b1;
          data_byte   <= w.b;
          end_of_data <= w.eod;
          restart     <= w.rs;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: random back-pressure, every accepted word against the oldest
  // expectation.
  // ---------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch_blk
    tag_word_t t;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        words_seen++;
        if (expected_tags.size() == 0) begin
          $error("unexpected word: role %0d, byte %0d", role, out_byte);
          mismatches++;
        end else begin
          t = expected_tags.pop_front();
          check_field("role", 8'(t.role), 8'(role));
          check_field("out_byte", t.b, out_byte);
          check_field("method_code", 8'(t.meth), 8'(method_code));
          check_field("version_code", 8'(t.ver), 8'(version_code));
          check_field("error_code", 8'(t.err), 8'(error_code));
          check_field("last_of_run", 8'(t.last), 8'(last_of_run));
          if (t.role == ROLE_DONE) heads_done++;
          if (t.role == ROLE_ERROR) heads_failed++;
        end
      end
      out_stall <= !calm && $urandom_range(99) < 20;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin
    // directed: every role, 0xFF in the path, then a CR that carries end
    // of data and a lone NUL, both truncating
    head_bytes.delete();
    put_string("GET ");
    put(8'hFF);
    put_string(" HTTP/1.1");
    put_crlf();
    put_string("K: v");
    put_crlf();
    put_crlf();
    send_head(1'b0);
    push_byte(CHAR_CR, 1'b1, 1'b1);
    push_byte(CHAR_NUL, 1'b0, 1'b1);

    fill_random(475);
    fill_random(475);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    wait (request_bytes.size() == 0 && !in_valid);
    wait (expected_tags.size() == 0);
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes (%0d accepted), checked %0d words.",
             bytes_queued, bytes_taken, words_seen);
    $display("Heads completed: %0d, heads rejected: %0d.", heads_done, heads_failed);
    if (mismatches == 0 && expected_tags.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #6_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
